// ===== design/svpm_pkg.sv =====
// Shared types and constants for the polyphonic voice pool mixer.
// Depends on nothing; imported by synth_voice_pool_mixer_core.
`timescale 1ns / 1ps
`default_nettype none

package svpm_pkg;

  localparam int unsigned PERIOD_W = 23;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 23'd89478;

  localparam logic [23:0] AMP_FULL   = 24'hFFFFFF;
  localparam logic [23:0] AMP_FLOOR  = 24'd1678;
  localparam logic [31:0] NOISE_SEED = 32'h12345678;

  // Quarter-wave sine polynomial coefficients, Q30.
  localparam logic [30:0] SC1 = 31'd1686629713;
  localparam logic [30:0] SC3 = 31'd693598670;
  localparam logic [30:0] SC5 = 31'd85569306;
  localparam logic [30:0] SC7 = 31'd5026995;

  localparam logic [1:0] WAVE_SQUARE   = 2'd0;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd1;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_NOTE = 1'b1;

  typedef struct packed {
    logic        action;
    logic [14:0] freq_hz;
    logic [1:0]  wave;
    logic [15:0] gain;
    logic [23:0] decay_factor;
    logic [19:0] delay_samples;
    logic [15:0] noise_mix;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] sample;
    logic [4:0]         voices_busy;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  wave;
    logic [31:0] step;
    logic [31:0] phase;
    logic [23:0] amp;
    logic [15:0] gain;
    logic [23:0] decay;
    logic [19:0] delay;
    logic [15:0] noise;
  } voice_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_N_MUL,
    ST_N_RD,
    ST_N_CMP,
    ST_N_LOAD,
    ST_V_RD,
    ST_V_EVAL,
    ST_S_X2,
    ST_S_T7,
    ST_S_T5,
    ST_S_M5,
    ST_S_T3,
    ST_S_M3,
    ST_S_T1,
    ST_S_MY,
    ST_S_Y,
    ST_X_N,
    ST_X_M,
    ST_X_SUM,
    ST_A_AMP,
    ST_A_GAIN,
    ST_A_DEC,
    ST_V_WB,
    ST_V_NEXT,
    ST_T_OUT
  } state_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] v);
    logic [31:0] x;
    x = v;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    return x;
  endfunction

endpackage

`default_nettype wire

// ===== design/synth_voice_pool_mixer_core.sv =====
// Polyphonic voice pool mixer: voice store, sequencer and one shared multiplier.
// Depends on svpm_pkg for the item, voice record and state types.
//
//   Channel  Signals                       Direction  Payload
//   in       in_valid/in_ready/in_data     input      tick or start-note item
//   out      out_valid/out_ready/out_data  output     mixed sample, busy count
//   cfg      cfg_valid/cfg_ready/cfg_data  input      sample_period register
//
// A tick visits each voice in turn: an idle one is skipped, a delayed one counts down, and
// a sounding one gives its square, triangle or sine sample, with noise mixed in if set;
// every multiply passes through the one registered 32x32 multiplier.
// A start-note item scans the voice store for a free voice, else the quietest one to steal.
// Reset is synchronous; it clears the active bits and reloads the noise seed and the period.
// A result waiting on out_ready does not block the next item; only the next
// tick's final transfer waits for the output register to empty.
`timescale 1ns / 1ps
`default_nettype none

module synth_voice_pool_mixer_core #(
  parameter int VOICES          = 16,
  parameter int SINE_TABLE_BITS = 10
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire svpm_pkg::in_item_t     in_data,
  output logic                        out_valid,
  input  wire                         out_ready,
  output svpm_pkg::out_item_t         out_data,
  input  wire                         cfg_valid,
  output logic                        cfg_ready,
  input  wire [svpm_pkg::PERIOD_W-1:0] cfg_data
);

  import svpm_pkg::*;

  localparam int VI_W   = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int BUSY_W = $clog2(VOICES + 1);
  localparam int SUM_W  = 25 + $clog2(VOICES);
  localparam int QLEN   = 1 << (SINE_TABLE_BITS - 2);
  localparam logic [VI_W-1:0] LAST = VI_W'(VOICES - 1);
  localparam logic signed [24:0] ONE_Q23 = 25'sd8388608;
  localparam logic signed [SUM_W-1:0] SUM_MAX = SUM_W'(8388607);
  localparam logic signed [SUM_W-1:0] SUM_MIN = SUM_W'(-8388608);

  state_t state, state_next;

  logic [VOICES-1:0]      active;
  logic [PERIOD_W-1:0]    sample_period;
  logic [31:0]            noise_state;
  logic [VI_W-1:0]        cnt;
  logic [VI_W-1:0]        pick;
  logic [23:0]            min_amp;
  in_item_t               in_q;

  voice_t                 mem [VOICES];
  voice_t                 rd_data;
  logic                   mem_we;
  logic [VI_W-1:0]        mem_wa;
  voice_t                 mem_wd;

  logic                   mul_en;
  logic signed [31:0]     mul_a, mul_b;
  logic signed [63:0]     prod;

  logic signed [24:0]     s_reg;
  logic signed [24:0]     n_reg;
  logic signed [41:0]     acc;
  logic [30:0]            x_reg;
  logic [30:0]            x2_reg;
  logic [30:0]            t_reg;
  logic                   neg_reg;
  logic signed [SUM_W-1:0] sum;
  logic [BUSY_W-1:0]      busy;

  // Combinational helpers on the voice being visited.
  logic [SINE_TABLE_BITS-1:0] s_idx;
  logic [1:0]                 s_quad;
  logic [SINE_TABLE_BITS-3:0] s_r;
  logic [SINE_TABLE_BITS-2:0] s_q;
  logic [30:0]                s_x;
  logic [31:0]                tri_d;
  logic signed [25:0]         tri_w;
  logic signed [24:0]         sq_val;
  logic [31:0]                noise_nx;
  logic signed [25:0]         noise_w;
  logic signed [41:0]         mix_sum;
  logic [31:0]                y_rnd;
  logic [24:0]                y_val;
  logic [23:0]                amp_new;
  logic signed [23:0]         sat;
  logic                       voice_sine;
  logic                       voice_noisy;

  always_comb begin
    s_idx   = rd_data.phase[31 -: SINE_TABLE_BITS];
    s_quad  = s_idx[SINE_TABLE_BITS-1 -: 2];
    s_r     = s_idx[SINE_TABLE_BITS-3:0];
    s_q     = s_quad[0] ? ((SINE_TABLE_BITS-1)'(QLEN) - {1'b0, s_r}) : {1'b0, s_r};
    s_x     = 31'(s_q) << (32 - SINE_TABLE_BITS);
    tri_d   = rd_data.phase[31] ? (rd_data.phase - 32'h80000000)
                                : (32'h80000000 - rd_data.phase);
    tri_w   = $signed({1'b0, tri_d[31:7]}) - 26'sd8388608;
    sq_val  = rd_data.phase[31] ? -ONE_Q23 : ONE_Q23;
    noise_nx = xorshift32(noise_state);
    noise_w = $signed({2'b00, noise_nx[31:8]}) - 26'sd8388608;
    mix_sum = acc + $signed(prod[41:0]);
    y_rnd   = {1'b0, prod[60:30]} + 32'd64;
    y_val   = (y_rnd[31:7] > 25'd8388608) ? 25'd8388608 : y_rnd[31:7];
    amp_new = prod[47:24];
    voice_sine  = (rd_data.wave != WAVE_SQUARE) && (rd_data.wave != WAVE_TRIANGLE);
    voice_noisy = (rd_data.noise != 16'd0);
    if (sum > SUM_MAX) begin
      sat = SUM_MAX[23:0];
    end else if (sum < SUM_MIN) begin
      sat = SUM_MIN[23:0];
    end else begin
      sat = sum[23:0];
    end
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_data.action == ACT_NOTE) ? ST_N_MUL : ST_V_RD;
        end
      end
      ST_N_MUL:  state_next = ST_N_RD;
      ST_N_RD:   state_next = active[cnt] ? ST_N_CMP : ST_N_LOAD;
      ST_N_CMP:  state_next = (cnt == LAST) ? ST_N_LOAD : ST_N_RD;
      ST_N_LOAD: state_next = ST_IDLE;
      ST_V_RD:   state_next = active[cnt] ? ST_V_EVAL : ST_V_NEXT;
      ST_V_EVAL: begin
        if (rd_data.delay != 20'd0) begin
          state_next = ST_V_NEXT;
        end else if (voice_sine) begin
          state_next = ST_S_X2;
        end else begin
          state_next = voice_noisy ? ST_X_N : ST_A_AMP;
        end
      end
      ST_S_X2:   state_next = ST_S_T7;
      ST_S_T7:   state_next = ST_S_T5;
      ST_S_T5:   state_next = ST_S_M5;
      ST_S_M5:   state_next = ST_S_T3;
      ST_S_T3:   state_next = ST_S_M3;
      ST_S_M3:   state_next = ST_S_T1;
      ST_S_T1:   state_next = ST_S_MY;
      ST_S_MY:   state_next = ST_S_Y;
      ST_S_Y:    state_next = voice_noisy ? ST_X_N : ST_A_AMP;
      ST_X_N:    state_next = ST_X_M;
      ST_X_M:    state_next = ST_X_SUM;
      ST_X_SUM:  state_next = ST_A_AMP;
      ST_A_AMP:  state_next = ST_A_GAIN;
      ST_A_GAIN: state_next = ST_A_DEC;
      ST_A_DEC:  state_next = ST_V_WB;
      ST_V_WB:   state_next = ST_V_NEXT;
      ST_V_NEXT: state_next = (cnt == LAST) ? ST_T_OUT : ST_V_RD;
      ST_T_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Multiplier operands, store writes and handshake outputs.
  always_comb begin
    in_ready  = (state == ST_IDLE);
    cfg_ready = 1'b1;
    mul_en    = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    mem_we    = 1'b0;
    mem_wa    = cnt;
    mem_wd    = rd_data;
    case (state)
      ST_N_MUL: begin
        mul_en = 1'b1;
        mul_a  = $signed({17'd0, in_q.freq_hz});
        mul_b  = $signed({9'd0, sample_period});
      end
      ST_N_LOAD: begin
        mem_we       = 1'b1;
        mem_wa       = pick;
        mem_wd.wave  = in_q.wave;
        mem_wd.step  = prod[31:0];
        mem_wd.phase = 32'd0;
        mem_wd.amp   = AMP_FULL;
        mem_wd.gain  = in_q.gain;
        mem_wd.decay = in_q.decay_factor;
        mem_wd.delay = in_q.delay_samples;
        mem_wd.noise = in_q.noise_mix;
      end
      ST_V_EVAL: begin
        if (rd_data.delay != 20'd0) begin
          mem_we       = 1'b1;
          mem_wd.delay = rd_data.delay - 20'd1;
        end
      end
      ST_S_X2: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, x_reg});
        mul_b  = $signed({1'b0, x_reg});
      end
      ST_S_T7: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, SC7});
        mul_b  = $signed({1'b0, prod[60:30]});
      end
      ST_S_M5, ST_S_M3: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, t_reg});
        mul_b  = $signed({1'b0, x2_reg});
      end
      ST_S_MY: begin
        mul_en = 1'b1;
        mul_a  = $signed({1'b0, t_reg});
        mul_b  = $signed({1'b0, x_reg});
      end
      ST_X_N: begin
        mul_en = 1'b1;
        mul_a  = {{7{s_reg[24]}}, s_reg};
        mul_b  = $signed({15'd0, 17'h10000 - {1'b0, rd_data.noise}});
      end
      ST_X_M: begin
        mul_en = 1'b1;
        mul_a  = {{7{n_reg[24]}}, n_reg};
        mul_b  = $signed({16'd0, rd_data.noise});
      end
      ST_A_AMP: begin
        mul_en = 1'b1;
        mul_a  = {{7{s_reg[24]}}, s_reg};
        mul_b  = $signed({8'd0, rd_data.amp});
      end
      ST_A_GAIN: begin
        mul_en = 1'b1;
        mul_a  = {{7{prod[48]}}, prod[48:24]};
        mul_b  = $signed({16'd0, rd_data.gain});
      end
      ST_A_DEC: begin
        mul_en = 1'b1;
        mul_a  = $signed({8'd0, rd_data.amp});
        mul_b  = $signed({8'd0, rd_data.decay});
      end
      ST_V_WB: begin
        mem_we       = 1'b1;
        mem_wd.phase = rd_data.phase + rd_data.step;
        mem_wd.amp   = amp_new;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Voice store: one write port, one registered read port addressed by cnt.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data <= mem[cnt];
  end

  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod <= 64'(mul_a) * 64'(mul_b);
    end
  end

  // Control state with reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      active        <= '0;
      sample_period <= PERIOD_RESET;
      noise_state   <= NOISE_SEED;
      out_valid     <= 1'b0;
      cnt           <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        sample_period <= cfg_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            cnt <= '0;
          end
        end
        ST_N_CMP, ST_V_NEXT: begin
          if (cnt != LAST) begin
            cnt <= cnt + 1'b1;
          end
        end
        ST_N_LOAD: active[pick] <= 1'b1;
        ST_X_N:    noise_state <= noise_nx;
        ST_V_WB: begin
          if (amp_new < AMP_FLOOR) begin
            active[cnt] <= 1'b0;
          end
        end
        ST_T_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          in_q <= in_data;
          sum  <= '0;
          busy <= '0;
        end
      end
      ST_N_RD: begin
        if (!active[cnt]) begin
          pick <= cnt;
        end
      end
      ST_N_CMP: begin
        // Only reached when every voice so far is sounding: steal the quietest.
        if ((cnt == '0) || (rd_data.amp < min_amp)) begin
          pick    <= cnt;
          min_amp <= rd_data.amp;
        end
      end
      ST_V_EVAL: begin
        if (rd_data.delay != 20'd0) begin
          busy <= busy + 1'b1;
        end else if (rd_data.wave == WAVE_SQUARE) begin
          s_reg <= sq_val;
        end else if (rd_data.wave == WAVE_TRIANGLE) begin
          s_reg <= tri_w[24:0];
        end else begin
          x_reg   <= s_x;
          neg_reg <= s_quad[1];
        end
      end
      ST_S_T7: x2_reg <= prod[60:30];
      ST_S_T5: t_reg  <= SC5 - prod[60:30];
      ST_S_T3: t_reg  <= SC3 - prod[60:30];
      ST_S_T1: t_reg  <= SC1 - prod[60:30];
      ST_S_Y:  s_reg  <= neg_reg ? -$signed(y_val) : $signed(y_val);
      ST_X_N:  n_reg  <= noise_w[24:0];
      ST_X_M:  acc    <= $signed(prod[41:0]);
      ST_X_SUM: s_reg <= mix_sum[40:16];
      ST_A_DEC: sum   <= sum + SUM_W'($signed(prod[40:16]));
      ST_V_WB: begin
        if (amp_new >= AMP_FLOOR) begin
          busy <= busy + 1'b1;
        end
      end
      ST_T_OUT: begin
        if (!out_valid || out_ready) begin
          out_data.sample      <= sat;
          out_data.voices_busy <= 5'(busy);
        end
      end
      default: begin
      end
    endcase
  end

  // A note goes to a free voice, or steals only when the pool is full.
  a_steal_only_when_full: assert property (@(posedge clk) disable iff (rst)
    (state == ST_N_LOAD) |-> (!active[pick] || (&active)))
    else $error("note start stole a voice while a free one existed");

  a_note_activates: assert property (@(posedge clk) disable iff (rst)
    (state == ST_N_LOAD) |=> active[$past(pick)])
    else $error("loaded voice is not active");

  a_noise_nonzero: assert property (@(posedge clk) disable iff (rst)
    noise_state != 32'd0)
    else $error("noise generator reached the all-zero state");

  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_T_OUT))
    else $error("result raised outside the end of a tick");

  a_busy_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((VOICES > 31) || (out_data.voices_busy <= 5'(VOICES))))
    else $error("busy count exceeds the pool size");

endmodule

`default_nettype wire

// ===== tb/sv/tb_synth_voice_pool_mixer_core.sv =====
// Self-checking testbench for synth_voice_pool_mixer_core: directed table, then random phases.
// Depends on svpm_pkg and the core; predicts each mixed sample with its own voice-pool model, except typed table rows.
`timescale 1ns / 1ps

module tb_synth_voice_pool_mixer_core;
  import svpm_pkg::*;

  localparam int VOICES    = 16;
  localparam int SINE_BITS = 10;
  localparam int PHASES    = 6;
  localparam int PHASE_ITEMS  = 90;
  localparam int NOTE_SETTLE  = 2 * VOICES + 32;
  localparam int TAIL_CYCLES  = 19 * VOICES + 100;
  localparam longint ONE_Q23  = 64'sd8388608;
  localparam longint MAX_Q23  = 64'sd8388607;

  localparam logic [1:0] WAVE_SINE     = 2'd2;
  localparam logic [1:0] WAVE_SINE_ALT = 2'd3;

  typedef struct packed {
    logic      typed;
    in_item_t  item;
    out_item_t want;
  } dir_row_t;

  logic                clk;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [PERIOD_W-1:0] cfg_data  = '0;

  // Model of the voice pool.
  voice_t              pool [VOICES];
  logic                pool_on [VOICES];
  logic [31:0]         noise_q;
  logic [PERIOD_W-1:0] period_q;

  out_item_t           due_samples [$];
  int                  errors = 0;
  bit                  in_calm = 1'b0;
  dir_row_t            dir_table [24];

  synth_voice_pool_mixer_core #(
    .VOICES          (VOICES),
    .SINE_TABLE_BITS (SINE_BITS)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(10_000_000);
    $display("Test completed with failures");
    $finish;
  end

  function automatic longint sine_level(input logic [31:0] ph);
    logic [31:0] idx, quad, r, q;
    logic [63:0] x, x2, t, y;
    longint      v;
    idx  = ph >> (32 - SINE_BITS);
    quad = idx >> (SINE_BITS - 2);
    r    = idx & ((32'd1 << (SINE_BITS - 2)) - 32'd1);
    q    = quad[0] ? (32'd1 << (SINE_BITS - 2)) - r : r;
    x    = q;
    x    = x << (32 - SINE_BITS);
    x2   = (x * x) >> 30;
    t    = SC7;
    t    = SC5 - ((t * x2) >> 30);
    t    = SC3 - ((t * x2) >> 30);
    t    = SC1 - ((t * x2) >> 30);
    y    = (t * x) >> 30;
    y    = (y + 64'd64) >> 7;
    if (y > 64'd8388608) y = 64'd8388608;
    v = y;
    return quad[1] ? -v : v;
  endfunction

  function automatic longint wave_level(input logic [1:0] w, input logic [31:0] ph);
    logic [31:0] d;
    longint      dv;
    if (w == WAVE_SQUARE) return ph[31] ? -ONE_Q23 : ONE_Q23;
    if (w == WAVE_TRIANGLE) begin
      d  = ph[31] ? ph - 32'h80000000 : 32'h80000000 - ph;
      dv = d >> 7;
      return dv - ONE_Q23;
    end
    return sine_level(ph);
  endfunction

  // Applies one item to the model; returns 1 with the mixed sample for a tick.
  function automatic bit pool_advance(input in_item_t it, output out_item_t res);
    int          i, pick, busy;
    bit          found;
    logic [63:0] prod;
    longint      s, n, m, mix;
    res = '0;
    if (it.action == ACT_NOTE) begin
      pick  = 0;
      found = 1'b0;
      for (i = 0; i < VOICES; i++)
        if (!found && !pool_on[i]) begin
          pick  = i;
          found = 1'b1;
        end
      // A full pool gives up its quietest voice, the lowest index on ties.
      if (!found)
        for (i = 1; i < VOICES; i++)
          if (pool[i].amp < pool[pick].amp) pick = i;
      prod = it.freq_hz * period_q;
      pool_on[pick]     = 1'b1;
      pool[pick].wave   = it.wave;
      pool[pick].step   = prod[31:0];
      pool[pick].phase  = '0;
      pool[pick].amp    = AMP_FULL;
      pool[pick].gain   = it.gain;
      pool[pick].decay  = it.decay_factor;
      pool[pick].delay  = it.delay_samples;
      pool[pick].noise  = it.noise_mix;
      return 1'b0;
    end
    mix  = 0;
    busy = 0;
    for (i = 0; i < VOICES; i++) begin
      if (pool_on[i]) begin
        if (pool[i].delay != '0) begin
          pool[i].delay = pool[i].delay - 20'd1;
          busy++;
        end else begin
          s = wave_level(pool[i].wave, pool[i].phase);
          if (pool[i].noise != 16'd0) begin
            noise_q = noise_q ^ (noise_q << 13);
            noise_q = noise_q ^ (noise_q >> 17);
            noise_q = noise_q ^ (noise_q << 5);
            n = noise_q >> 8;
            n = n - ONE_Q23;
            m = pool[i].noise;
            s = (s * (65536 - m) + n * m) >>> 16;
          end
          m   = pool[i].amp;
          s   = (s * m) >>> 24;
          m   = pool[i].gain;
          s   = (s * m) >>> 16;
          mix = mix + s;
          pool[i].phase = pool[i].phase + pool[i].step;
          prod          = pool[i].amp * pool[i].decay;
          pool[i].amp   = prod[47:24];
          if (pool[i].amp < AMP_FLOOR) pool_on[i] = 1'b0;
          else busy++;
        end
      end
    end
    if (mix > MAX_Q23) mix = MAX_Q23;
    if (mix < -ONE_Q23) mix = -ONE_Q23;
    res.sample      = mix[23:0];
    res.voices_busy = busy[4:0];
    return 1'b1;
  endfunction

  function automatic in_item_t rand_tick();
    logic [95:0] raw;
    in_item_t    it;
    raw = {$urandom, $urandom, $urandom};
    it  = raw[93:0];
    it.action = ACT_TICK;
    return it;
  endfunction

  function automatic in_item_t rand_note();
    in_item_t    it;
    int unsigned pick;
    it = rand_tick();
    it.action = ACT_NOTE;
    pick = $urandom_range(3, 0);
    if (pick == 1 || pick == 2) it.freq_hz = 15'($urandom_range(4000, 20));
    else if (pick == 3) it.freq_hz = 15'($urandom_range(24000, 0));
    // Most notes die within a few dozen ticks so that voices come and go.
    pick = $urandom_range(19, 0);
    if (pick == 0) it.decay_factor = '0;
    else if (pick == 1) it.decay_factor = AMP_FULL;
    else if (pick > 3) it.decay_factor = 24'($urandom_range(24'hF80000, 24'hA00000));
    pick = $urandom_range(99, 0);
    if (pick > 0 && pick <= 40) it.delay_samples = '0;
    else if (pick > 40) it.delay_samples = 20'($urandom_range(6, 0));
    if ($urandom_range(1, 0) == 0) it.noise_mix = '0;
    if ($urandom_range(7, 0) == 0) it.gain = 16'hFFFF;
    return it;
  endfunction

  // Leaves the previous valid high when there is no gap, so it is never lowered and raised
  // again within one step.
  task automatic push_item(input in_item_t it, input bit typed, input out_item_t want);
    int unsigned gap;
    out_item_t   res;
    if ($urandom_range(29, 0) == 0) in_calm = !in_calm;
    gap = in_calm ? 0 : $urandom_range(4, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (pool_advance(it, res)) due_samples.push_back(typed ? want : res);
  endtask

  // A start-note item gives no result, so it may still be in flight when the queue empties.
  task automatic settle();
    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (NOTE_SETTLE) @(posedge clk);
  endtask

  task automatic write_period(input logic [PERIOD_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    period_q = v;
  endtask

  initial begin
    int unsigned hold;
    bit          calm;
    calm = 1'b0;
    @(posedge clk);
    forever begin
      if ($urandom_range(39, 0) == 0) calm = !calm;
      hold = calm ? 0 : $urandom_range(4, 0);
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (rst || !out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_samples.size() == 0) begin
        $error("unexpected result transfer: sample %0d, voices_busy %0d",
               out_data.sample, out_data.voices_busy);
        errors++;
      end else begin
        want = due_samples.pop_front();
        if (out_data.sample !== want.sample) begin
          $error("sample: expected %0d, got %0d", want.sample, out_data.sample);
          errors++;
        end
        if (out_data.voices_busy !== want.voices_busy) begin
          $error("voices_busy: expected %0d, got %0d", want.voices_busy, out_data.voices_busy);
          errors++;
        end
      end
    end
  end

  initial begin
    logic [PERIOD_W-1:0] plan [PHASES];
    int                  k, ph, sent, burst;
    out_item_t           none;

    none = '0;
    for (k = 0; k < VOICES; k++) begin
      pool_on[k] = 1'b0;
      pool[k]    = '0;
    end
    noise_q  = NOISE_SEED;
    period_q = PERIOD_RESET;

    // typed action freq wave gain decay delay noise | sample busy
    dir_table = '{
      {1'b1, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd24000, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b1, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd1000, WAVE_TRIANGLE, 16'hFFFF, 24'hC00000, 20'd2, 16'd0,
       24'd0, 5'd0},
      {1'b1, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd1},
      {1'b1, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd1},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd440, WAVE_SINE, 16'h8000, 24'hF00000, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd32767, WAVE_SINE_ALT, 16'hFFFF, 24'h400000, 20'd0, 16'hFFFF,
       24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd0, WAVE_SQUARE, 16'hFFFF, 24'h800000, 20'd0, 16'd1, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd12345, WAVE_TRIANGLE, 16'd1, 24'h7FFFFF, 20'd1, 16'h8000,
       24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd0, WAVE_SQUARE, 16'hFFFF, 24'hFFFFFF, 20'hFFFFF, 16'd0,
       24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd12000, WAVE_SQUARE, 16'hFFFF, 24'hFFFFFF, 20'd0, 16'd0,
       24'd0, 5'd0},
      {1'b0, ACT_NOTE, 15'd12000, WAVE_SQUARE, 16'hFFFF, 24'hFFFFFF, 20'd0, 16'd0,
       24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0},
      {1'b0, ACT_TICK, 15'd0, WAVE_SQUARE, 16'd0, 24'd0, 20'd0, 16'd0, 24'd0, 5'd0}
    };

    // Lowest and highest period, zero and the full 23-bit value, then a random one and reset.
    plan = '{23'd1, 23'd0, 23'd4294967, 23'h7FFFFF, 23'd0, PERIOD_RESET};
    plan[4] = PERIOD_W'($urandom_range(4294967, 1));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    write_period(PERIOD_RESET);

    for (k = 0; k < 24; k++)
      push_item(dir_table[k].item, dir_table[k].typed, dir_table[k].want);

    for (ph = 0; ph < PHASES; ph++) begin
      settle();
      write_period(plan[ph]);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // Bursts of notes fill the pool so that voices get stolen.
        burst = ($urandom_range(19, 0) == 0) ? $urandom_range(18, 8) : 0;
        if (burst > 0) begin
          repeat (burst) push_item(rand_note(), 1'b0, none);
          sent += burst;
        end else begin
          if ($urandom_range(9, 0) < 3) push_item(rand_note(), 1'b0, none);
          else push_item(rand_tick(), 1'b0, none);
          sent++;
        end
      end
    end

    in_valid <= 1'b0;
    while (due_samples.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
